@@ sv/filename_escape_encoder_macros.svh @@
// assertion macros for the filename escape encoder
// expects clk_i and rst_ni in the scope of each use
`ifndef FILENAME_ESCAPE_ENCODER_MACROS_SVH
`define FILENAME_ESCAPE_ENCODER_MACROS_SVH

// clocked check, switched off while in reset
`define FEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds through reset
`define FEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/fee_pkg.sv @@
// types and constants of the filename escape encoder
// no dependencies
package fee_pkg;

  localparam int unsigned CharW = 16;
  localparam int unsigned RunMax = 5;
  localparam int unsigned CntW = 3;

  localparam logic [CharW-1:0] ChrNul       = 16'h0000;
  localparam logic [CharW-1:0] ChrCtrlMax   = 16'h001f;
  localparam logic [CharW-1:0] ChrDel       = 16'h007f;
  localparam logic [CharW-1:0] ChrSlash     = 16'h002f;
  localparam logic [CharW-1:0] ChrBackslash = 16'h005c;
  localparam logic [CharW-1:0] ChrCaret     = 16'h005e;
  localparam logic [CharW-1:0] ChrX         = 16'h0078;
  localparam logic [CharW-1:0] ChrZero      = 16'h0030;
  localparam logic [CharW-1:0] ChrA         = 16'h0061;

  localparam logic [CntW-1:0] CntOne  = 3'd1;
  localparam logic [CntW-1:0] CntTwo  = 3'd2;
  localparam logic [CntW-1:0] CntFour = 3'd4;

  typedef enum logic {
    ModeBackslash = 1'b0,
    ModeCaret     = 1'b1
  } mode_e;

  typedef struct packed {
    logic [CharW-1:0] char_value;
    logic             end_of_name;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             run_last;
  } out_t;

  typedef struct packed {
    logic [RunMax-1:0][CharW-1:0] chars;
    logic [CntW-1:0]              cnt;
    logic                         aterm_next;
  } run_t;

  // lower-case hex digit of a nibble
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] r;
    if (nib <= 4'h9) begin
      r = ChrZero + {12'h000, nib};
    end else begin
      r = ChrA + {12'h000, nib} - 16'd10;
    end
    return r;
  endfunction

endpackage

@@ sv/fee_expand.sv @@
// expands one character item into its run of result characters
// depends on fee_pkg
module fee_expand (
  input  fee_pkg::in_t  item_i,
  input  fee_pkg::mode_e mode_i,
  input  logic          aterm_i,
  output fee_pkg::run_t run_o
);

  logic [fee_pkg::CharW-1:0] c;
  logic [fee_pkg::CharW-1:0] esc;
  logic [fee_pkg::CharW-1:0] sep;
  logic                      last;

  assign c    = item_i.char_value;
  assign last = item_i.end_of_name;

  always_comb begin
    unique case (mode_i)
      fee_pkg::ModeCaret: begin
        esc = fee_pkg::ChrCaret;
        sep = fee_pkg::ChrBackslash;
      end
      default: begin
        esc = fee_pkg::ChrBackslash;
        sep = fee_pkg::ChrSlash;
      end
    endcase
  end

  // unused slots stay zero, so the terminator after a run needs only a count bump
  always_comb begin
    run_o.chars      = '0;
    run_o.cnt        = '0;
    run_o.aterm_next = aterm_i;
    priority if (aterm_i) begin
      // swallow items until the end of the name
      run_o.aterm_next = !last;
    end else if (c == fee_pkg::ChrNul) begin
      run_o.cnt        = fee_pkg::CntOne;
      run_o.aterm_next = !last;
    end else begin
      priority if (c <= fee_pkg::ChrCtrlMax || c == fee_pkg::ChrDel || c == sep) begin
        run_o.chars[0] = esc;
        run_o.chars[1] = fee_pkg::ChrX;
        run_o.chars[2] = fee_pkg::hex_char(c[7:4]);
        run_o.chars[3] = fee_pkg::hex_char(c[3:0]);
        run_o.cnt      = fee_pkg::CntFour;
      end else if (c == esc) begin
        run_o.chars[0] = esc;
        run_o.chars[1] = esc;
        run_o.cnt      = fee_pkg::CntTwo;
      end else begin
        run_o.chars[0] = c;
        run_o.cnt      = fee_pkg::CntOne;
      end
      run_o.cnt = run_o.cnt + {2'b00, last};
    end
  end

endmodule

@@ sv/filename_escape_encoder.sv @@
// an item is registered in the input register, then expanded into the run register;
// its results are offered from there, one result per cycle while out_ready_i is high
// throughput: one item per cycle for plain characters when the output does not stall;
// a longer run, up to five characters, holds the run register and back-pressures input
// reset: asynchronous, active low; clears valid flags, mode and terminator state
// depends on fee_pkg, fee_expand and filename_escape_encoder_macros.svh
`include "filename_escape_encoder_macros.svh"

module filename_escape_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  fee_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output fee_pkg::out_t out_data_o
);

  fee_pkg::mode_e mode_q;
  logic           aterm_q;

  fee_pkg::in_t item_q;
  logic         item_valid_q;

  logic [fee_pkg::RunMax-1:0][fee_pkg::CharW-1:0] run_q;
  logic [fee_pkg::CntW-1:0]                       run_cnt_q;
  logic [fee_pkg::CntW-1:0]                       run_idx_q;
  logic                                           run_valid_q;

  fee_pkg::run_t exp;
  logic          at_last;
  logic          run_free;
  logic          move;
  logic          in_acc;
  logic          out_acc;

  fee_expand u_expand (
    .item_i (item_q),
    .mode_i (mode_q),
    .aterm_i(aterm_q),
    .run_o  (exp)
  );

  assign at_last  = run_idx_q == (run_cnt_q - fee_pkg::CntOne);
  assign run_free = !run_valid_q || (out_ready_i && at_last);
  assign move     = item_valid_q && run_free;
  assign in_ready_o = !item_valid_q || run_free;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;

  assign out_valid_o         = run_valid_q;
  assign out_data_o.out_char = run_q[run_idx_q];
  assign out_data_o.run_last = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fee_pkg::ModeBackslash;
    end else if (cfg_we_i) begin
      mode_q <= fee_pkg::mode_e'(cfg_wdata_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_acc) begin
      item_valid_q <= 1'b1;
    end else if (move) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  // run register, drained one character per accepted result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
      run_cnt_q   <= '0;
      aterm_q     <= 1'b0;
    end else if (move) begin
      run_valid_q <= exp.cnt != '0;
      run_idx_q   <= '0;
      run_cnt_q   <= exp.cnt;
      aterm_q     <= exp.aterm_next;
    end else if (out_acc) begin
      if (at_last) begin
        run_valid_q <= 1'b0;
      end else begin
        run_idx_q <= run_idx_q + fee_pkg::CntOne;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      run_q <= exp.chars;
    end
  end

  `FEE_ASSERT(a_idx_in_run, run_valid_q |-> (run_idx_q < run_cnt_q), "run index past run end")
  `FEE_ASSERT(a_idx_step, out_acc && !at_last |=> $changed(run_idx_q), "index stuck")
  `FEE_ASSERT(a_item_kept, item_valid_q && !run_free |=> item_valid_q && $stable(item_q), "item lost")
  `FEE_ASSERT(a_cnt_bound, run_cnt_q <= 3'(fee_pkg::RunMax), "run count out of range")
  `FEE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result offered after reset")

endmodule

@@ test/filename_escape_encoder_tb.sv @@
// testbench of the filename escape encoder: a shadow encoder predicts every output
// character and a monitor checks them in order under random idling and back-pressure
// depends on fee_pkg and the filename_escape_encoder rtl
module filename_escape_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CharW        = fee_pkg::CharW;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned PhaseItems   = 26;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic          cfg_wdata_i = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  fee_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  fee_pkg::out_t out_data_o;

  fee_pkg::in_t   name_items_q[$];
  fee_pkg::out_t  escaped_q[$];
  fee_pkg::mode_e cur_mode       = fee_pkg::ModeBackslash;
  logic           after_nul      = 1'b0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  logic           hold_req       = 1'b0;
  int unsigned    hold_cnt       = 0;
  int unsigned    mismatch_cnt   = 0;
  int unsigned    quiet_cycles   = 0;

  always #1 clk_i = ~clk_i;

  filename_escape_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  function automatic logic [CharW-1:0] nib_to_hex(input logic [3:0] nib);
    logic [CharW-1:0] d;
    if (nib < 4'd10) begin
      d = fee_pkg::ChrZero + {12'h000, nib};
    end else begin
      d = fee_pkg::ChrA + {12'h000, nib} - 16'd10;
    end
    return d;
  endfunction

  // shadow encoder: queues the escaped characters one accepted item gives
  task automatic expand_char(input fee_pkg::in_t it);
    logic [CharW-1:0] esc_c;
    logic [CharW-1:0] sep_c;
    logic [CharW-1:0] run_chars[fee_pkg::RunMax];
    int               n;
    fee_pkg::out_t    o;
    esc_c = (cur_mode == fee_pkg::ModeCaret) ? fee_pkg::ChrCaret : fee_pkg::ChrBackslash;
    sep_c = (cur_mode == fee_pkg::ModeCaret) ? fee_pkg::ChrBackslash : fee_pkg::ChrSlash;
    n = 0;
    if (after_nul) begin
      // rest of the name is dropped, end of name rearms
      if (it.end_of_name) begin
        after_nul = 1'b0;
      end
    end else if (it.char_value == fee_pkg::ChrNul) begin
      run_chars[n++] = fee_pkg::ChrNul;
      if (!it.end_of_name) begin
        after_nul = 1'b1;
      end
    end else begin
      if (it.char_value <= fee_pkg::ChrCtrlMax || it.char_value == fee_pkg::ChrDel ||
          it.char_value == sep_c) begin
        run_chars[n++] = esc_c;
        run_chars[n++] = fee_pkg::ChrX;
        run_chars[n++] = nib_to_hex(it.char_value[7:4]);
        run_chars[n++] = nib_to_hex(it.char_value[3:0]);
      end else if (it.char_value == esc_c) begin
        run_chars[n++] = esc_c;
        run_chars[n++] = esc_c;
      end else begin
        run_chars[n++] = it.char_value;
      end
      if (it.end_of_name) begin
        run_chars[n++] = fee_pkg::ChrNul;
      end
    end
    for (int k = 0; k < n; k++) begin
      o.out_char = run_chars[k];
      o.run_last = (k == n - 1);
      escaped_q.push_back(o);
    end
  endtask

  function automatic logic [CharW-1:0] rand_char();
    logic [CharW-1:0] c;
    case ($urandom_range(15, 0))
      0:       c = fee_pkg::ChrNul;
      1, 2:    c = CharW'($urandom_range(31, 1));
      3:       c = fee_pkg::ChrDel;
      4:       c = fee_pkg::ChrSlash;
      5:       c = fee_pkg::ChrBackslash;
      6:       c = fee_pkg::ChrCaret;
      7, 8:    c = CharW'($urandom_range(65535, 0));
      default: c = CharW'($urandom_range(126, 32));
    endcase
    return c;
  endfunction

  task automatic add_item(input logic [CharW-1:0] c, input logic eon);
    fee_pkg::in_t it;
    it.char_value  = c;
    it.end_of_name = eon;
    name_items_q.push_back(it);
  endtask

  // mostly whole names, some loose items with a random end flag
  task automatic queue_names(input int unsigned n_items);
    int unsigned cnt;
    int unsigned len;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(99, 0) < 85) begin
        len = $urandom_range(6, 1);
        for (int unsigned k = 0; k < len; k++) begin
          add_item(rand_char(), k == len - 1);
        end
        cnt += len;
      end else begin
        add_item(rand_char(), 1'($urandom_range(1, 0)));
        cnt++;
      end
    end
  endtask

  task automatic set_mode(input fee_pkg::mode_e m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode = m;
  endtask

  // items after a terminator give nothing, so wait a settle time after the queues empty
  task automatic wait_drained();
    @(negedge clk_i);
    while (name_items_q.size() != 0 || in_valid_i || escaped_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input fee_pkg::mode_e m, input int unsigned s_pct,
                           input int unsigned r_pct, input logic hold);
    set_mode(m);
    @(negedge clk_i);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    hold_req       = hold;
    queue_names(PhaseItems);
    wait_drained();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expand_char(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (name_items_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_data_i  <= name_items_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    fee_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (escaped_q.size() == 0) begin
          $error("unexpected item: out_char %h run_last %b",
                 out_data_o.out_char, out_data_o.run_last);
          mismatch_cnt++;
        end else begin
          want = escaped_q.pop_front();
          if (out_data_o.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_data_o.out_char);
            mismatch_cnt++;
          end
          if (out_data_o.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_data_o.run_last);
            mismatch_cnt++;
          end
        end
      end
      // one long hold-off so the block fills up and stalls its input
      if (hold_req && hold_cnt < HoldCycles) begin
        hold_cnt    <= hold_cnt + 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_mode(fee_pkg::ModeBackslash);
    @(negedge clk_i);
    // plain, control, delete, separator, escape and wide characters
    add_item(16'h0061, 1'b0);
    add_item(16'h0001, 1'b0);
    add_item(fee_pkg::ChrCtrlMax, 1'b0);
    add_item(fee_pkg::ChrDel, 1'b0);
    add_item(fee_pkg::ChrSlash, 1'b0);
    add_item(fee_pkg::ChrBackslash, 1'b0);
    add_item(fee_pkg::ChrCaret, 1'b0);
    add_item(16'h0020, 1'b0);
    add_item(16'h0080, 1'b0);
    add_item(16'hffff, 1'b0);
    add_item(16'h007e, 1'b1);
    // zero mid-name, dropped items, then end of name with no output
    add_item(16'h0041, 1'b0);
    add_item(fee_pkg::ChrNul, 1'b0);
    add_item(16'h0001, 1'b0);
    add_item(16'hffff, 1'b0);
    add_item(16'h0041, 1'b1);
    // zero that ends the name gives a single terminator
    add_item(fee_pkg::ChrNul, 1'b1);
    add_item(fee_pkg::ChrBackslash, 1'b1);
    add_item(16'h0010, 1'b1);
    add_item(16'haaaa, 1'b1);
    add_item(16'h5555, 1'b0);
    add_item(fee_pkg::ChrNul, 1'b1);
    wait_drained();

    run_phase(fee_pkg::ModeCaret, 0, 0, 1'b0);
    run_phase(fee_pkg::ModeBackslash, 78, 0, 1'b0);
    run_phase(fee_pkg::ModeCaret, 0, 78, 1'b0);
    run_phase(fee_pkg::ModeBackslash, 12, 12, 1'b0);
    run_phase(fee_pkg::ModeCaret, 0, 0, 1'b1);

    if (mismatch_cnt == 0 && escaped_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
